### design/epm_pkg.sv
// Shared types, widths, latencies and Taylor-series divisors for the Euler placement matrix.
// Used by every module in the design folder; depends on nothing.
package epm_pkg;

  localparam int ANGLE_BITS_DEFAULT = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int COORD_WIDTH = 32;
  localparam int TRIG_WIDTH = 17;
  localparam int ELEM_WIDTH = 18;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;

  localparam int TAYLOR_TERMS = 7;
  localparam int SIN_TERMS = 6;
  localparam int TERM_STAGES = 3;

  localparam int SC_LATENCY = 2 + TAYLOR_TERMS * TERM_STAGES + 1;
  localparam int ROT_LATENCY = 3;
  localparam int SCALE_LATENCY = 2;
  localparam int PIPE_DEPTH = SC_LATENCY + ROT_LATENCY + SCALE_LATENCY;

  localparam logic [7:0] SIN_DIV [TAYLOR_TERMS] =
    '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
  localparam logic [7:0] COS_DIV [TAYLOR_TERMS] =
    '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};

  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic signed [TRIG_WIDTH-1:0] trig_t;
  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] scale;
    logic [2:0][COORD_WIDTH-1:0] location;
  } side_t;

endpackage

### design/epm_term.sv
// One Taylor-series term in three register stages: multiply by x squared, divide by a
// constant through a reciprocal multiply with a one-step correction, then accumulate.
// Depends on epm_pkg.
module epm_term #(
  parameter logic [7:0] DIV = 8'd2,
  parameter bit SUBTRACT = 1'b1,
  parameter bit ACCUMULATE = 1'b1
) (
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        t_in,
  input  logic [31:0]        x2_in,
  input  logic signed [33:0] sum_in,
  output logic [30:0]        t_out,
  output logic [31:0]        x2_out,
  output logic signed [33:0] sum_out
);

  localparam logic [31:0] RECIP = 32'(epm_pkg::TWO_POW_32 / 33'(DIV));

  logic [62:0]        prod_a;
  logic [31:0]        p_a;
  logic [31:0]        x2_a;
  logic signed [33:0] sum_a;

  logic [63:0]        prod_b;
  logic [31:0]        q_b;
  logic [31:0]        p_b;
  logic [31:0]        x2_b;
  logic signed [33:0] sum_b;

  logic [31:0]        rem;
  logic [31:0]        q;
  logic signed [33:0] q_s;

  assign prod_a = 63'(t_in) * 63'(x2_in);
  assign prod_b = 64'(p_a) * 64'(RECIP);
  assign rem = p_b - (q_b * 32'(DIV));
  assign q = (rem >= 32'(DIV)) ? q_b + 32'd1 : q_b;
  assign q_s = $signed({2'b00, q});

  always_ff @(posedge clk) begin
    if (en) begin
      p_a <= prod_a[61:30];
      x2_a <= x2_in;
      sum_a <= sum_in;
      q_b <= prod_b[63:32];
      p_b <= p_a;
      x2_b <= x2_a;
      sum_b <= sum_a;
      t_out <= q[30:0];
      x2_out <= x2_b;
      if (!ACCUMULATE) begin
        sum_out <= sum_b;
      end else if (SUBTRACT) begin
        sum_out <= sum_b - q_s;
      end else begin
        sum_out <= sum_b + q_s;
      end
    end
  end

endmodule

### design/epm_sincos.sv
// Pipelined sine and cosine of one angle at 15 fractional bits: radian conversion, x squared,
// seven Taylor term stages for each function, then rounding, clamping and quadrant mapping.
// Depends on epm_pkg and epm_term.
module epm_sincos #(
  parameter int ANGLE_BITS = epm_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [epm_pkg::ANGLE_WIDTH-1:0]    angle,
  output epm_pkg::trig_t                     sn,
  output epm_pkg::trig_t                     cs
);

  localparam int RW = ANGLE_BITS - 2;
  localparam int PW = RW + 31;
  localparam int NT = epm_pkg::TAYLOR_TERMS;
  localparam int QD = epm_pkg::SC_LATENCY - 1;

  localparam logic [1:0] QUAD_FIRST = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD = 2'd2;

  logic [RW-1:0]      r;
  logic [PW-1:0]      xprod;
  logic [30:0]        x1;
  logic [61:0]        xsq;
  logic [30:0]        x_2;
  logic [31:0]        x2_2;
  logic [1:0]         quad_d [1:QD];

  logic [30:0]        s_t   [NT+1];
  logic [31:0]        s_x2  [NT+1];
  logic signed [33:0] s_sum [NT+1];
  logic [30:0]        c_t   [NT+1];
  logic [31:0]        c_x2  [NT+1];
  logic signed [33:0] c_sum [NT+1];

  logic [15:0]        s_mag;
  logic [15:0]        c_mag;
  epm_pkg::trig_t     s_pos;
  epm_pkg::trig_t     c_pos;

  function automatic logic [15:0] round_clamp(input logic signed [33:0] v);
    logic signed [33:0] w;
    w = (v + 34'sd16384) >>> 15;
    if (w < 34'sd0) begin
      return 16'd0;
    end else if (w > 34'sd32768) begin
      return 16'h8000;
    end
    return w[15:0];
  endfunction

  assign r = angle[RW-1:0];
  assign xprod = PW'(r) * PW'(epm_pkg::HALF_PI_Q30) + (PW'(1) << (RW - 1));
  assign xsq = 62'(x1) * 62'(x1);

  assign s_t[0] = x_2;
  assign s_x2[0] = x2_2;
  assign s_sum[0] = $signed({3'b000, x_2});
  assign c_t[0] = 31'h4000_0000;
  assign c_x2[0] = x2_2;
  assign c_sum[0] = 34'sh4000_0000;

  for (genvar k = 0; k < NT; k++) begin : g_term
    epm_term #(
      .DIV(epm_pkg::SIN_DIV[k]),
      .SUBTRACT((k % 2) == 0),
      .ACCUMULATE(k < epm_pkg::SIN_TERMS)
    ) u_sin (
      .clk(clk), .en(en),
      .t_in(s_t[k]), .x2_in(s_x2[k]), .sum_in(s_sum[k]),
      .t_out(s_t[k+1]), .x2_out(s_x2[k+1]), .sum_out(s_sum[k+1])
    );
    epm_term #(
      .DIV(epm_pkg::COS_DIV[k]),
      .SUBTRACT((k % 2) == 0),
      .ACCUMULATE(1'b1)
    ) u_cos (
      .clk(clk), .en(en),
      .t_in(c_t[k]), .x2_in(c_x2[k]), .sum_in(c_sum[k]),
      .t_out(c_t[k+1]), .x2_out(c_x2[k+1]), .sum_out(c_sum[k+1])
    );
  end

  assign s_mag = round_clamp(s_sum[NT]);
  assign c_mag = round_clamp(c_sum[NT]);
  assign s_pos = $signed({1'b0, s_mag});
  assign c_pos = $signed({1'b0, c_mag});

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= xprod[RW +: 31];
      x_2 <= x1;
      x2_2 <= xsq[61:30];
      quad_d[1] <= angle[ANGLE_BITS-1 -: 2];
      for (int k = 2; k <= QD; k++) begin
        quad_d[k] <= quad_d[k-1];
      end
      case (quad_d[QD])
        QUAD_FIRST: begin
          sn <= s_pos;
          cs <= c_pos;
        end
        QUAD_SECOND: begin
          sn <= c_pos;
          cs <= -s_pos;
        end
        QUAD_THIRD: begin
          sn <= -s_pos;
          cs <= -c_pos;
        end
        default: begin
          sn <= -c_pos;
          cs <= s_pos;
        end
      endcase
    end
  end

endmodule

### design/epm_rotate.sv
// Three-stage pitch-yaw-roll rotation: pairwise trig products, triple products, then sums
// rounded once to 15 fractional bits. Depends on epm_pkg.
module epm_rotate (
  input  logic           clk,
  input  logic           en,
  input  epm_pkg::trig_t sp,
  input  epm_pkg::trig_t cp,
  input  epm_pkg::trig_t sy,
  input  epm_pkg::trig_t cy,
  input  epm_pkg::trig_t sr,
  input  epm_pkg::trig_t cr,
  output epm_pkg::elem_t e [3][3]
);

  logic signed [31:0] p_cpcy, p_cpsy, p_srsp, p_crsy, p_crcy;
  logic signed [31:0] p_srcp, p_crsp, p_srsy, p_srcy, p_crcp;
  epm_pkg::trig_t     sp1, sy1, cy1;

  logic signed [46:0] t_a, t_b, t_c, t_d;
  logic signed [31:0] q_crsy, q_crcy, q_srsy, q_srcy;
  epm_pkg::elem_t     e00, e01, e02, e12, e22;

  logic signed [47:0] v10, v11, v20, v21;

  function automatic epm_pkg::elem_t round15(input logic signed [31:0] v);
    logic signed [31:0] w;
    w = (v + 32'sd16384) >>> 15;
    return w[epm_pkg::ELEM_WIDTH-1:0];
  endfunction

  function automatic epm_pkg::elem_t round30(input logic signed [47:0] v);
    logic signed [47:0] w;
    w = (v + 48'sd536870912) >>> 30;
    return w[epm_pkg::ELEM_WIDTH-1:0];
  endfunction

  assign v10 = 48'(t_a) - (48'(q_crsy) <<< 15);
  assign v11 = 48'(t_b) + (48'(q_crcy) <<< 15);
  assign v20 = -(48'(t_c) + (48'(q_srsy) <<< 15));
  assign v21 = (48'(q_srcy) <<< 15) - 48'(t_d);

  always_ff @(posedge clk) begin
    if (en) begin
      p_cpcy <= 32'(cp) * 32'(cy);
      p_cpsy <= 32'(cp) * 32'(sy);
      p_srsp <= 32'(sr) * 32'(sp);
      p_crsy <= 32'(cr) * 32'(sy);
      p_crcy <= 32'(cr) * 32'(cy);
      p_srcp <= 32'(sr) * 32'(cp);
      p_crsp <= 32'(cr) * 32'(sp);
      p_srsy <= 32'(sr) * 32'(sy);
      p_srcy <= 32'(sr) * 32'(cy);
      p_crcp <= 32'(cr) * 32'(cp);
      sp1 <= sp;
      sy1 <= sy;
      cy1 <= cy;

      t_a <= 47'(p_srsp) * 47'(cy1);
      t_b <= 47'(p_srsp) * 47'(sy1);
      t_c <= 47'(p_crsp) * 47'(cy1);
      t_d <= 47'(p_crsp) * 47'(sy1);
      q_crsy <= p_crsy;
      q_crcy <= p_crcy;
      q_srsy <= p_srsy;
      q_srcy <= p_srcy;
      e00 <= round15(p_cpcy);
      e01 <= round15(p_cpsy);
      e02 <= epm_pkg::ELEM_WIDTH'(sp1);
      e12 <= round15(-p_srcp);
      e22 <= round15(p_crcp);

      e[0][0] <= e00;
      e[0][1] <= e01;
      e[0][2] <= e02;
      e[1][0] <= round30(v10);
      e[1][1] <= round30(v11);
      e[1][2] <= e12;
      e[2][0] <= round30(v20);
      e[2][1] <= round30(v21);
      e[2][2] <= e22;
    end
  end

endmodule

### design/euler_placement_matrix.sv
// Euler placement matrix top level: per request, three pitch-yaw-roll rotation rows scaled
// per axis, then the location row, one row per cycle while result_stall is low. A request
// enters the 29-stage pipeline; the row sequencer at the output sends four rows per request,
// and the pipeline keeps accepting requests meanwhile, stalling only when its last stage is
// full and the sequencer is busy. Depends on epm_pkg, epm_sincos and epm_rotate.
module euler_placement_matrix #(
  parameter int ANGLE_BITS = epm_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             request_valid,
  output logic                             request_stall,
  input  logic [epm_pkg::ANGLE_WIDTH-1:0]  pitch_angle,
  input  logic [epm_pkg::ANGLE_WIDTH-1:0]  yaw_angle,
  input  logic [epm_pkg::ANGLE_WIDTH-1:0]  roll_angle,
  input  epm_pkg::coord_t                  scale_x,
  input  epm_pkg::coord_t                  scale_y,
  input  epm_pkg::coord_t                  scale_z,
  input  epm_pkg::coord_t                  location_x,
  input  epm_pkg::coord_t                  location_y,
  input  epm_pkg::coord_t                  location_z,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       row_number,
  output epm_pkg::coord_t                  first_column,
  output epm_pkg::coord_t                  second_column,
  output epm_pkg::coord_t                  third_column,
  output logic                             homogeneous_one,
  output logic                             last_row
);

  localparam int DEPTH = epm_pkg::PIPE_DEPTH;
  localparam int ROT_END = epm_pkg::SC_LATENCY + epm_pkg::ROT_LATENCY;

  logic              en;
  logic              take;
  logic              out_done;
  logic [DEPTH:1]    valid;
  epm_pkg::side_t    side_in;
  epm_pkg::side_t    side [1:DEPTH];

  epm_pkg::trig_t    sp, cp, sy, cy, sr, cr;
  epm_pkg::elem_t    e [3][3];
  logic signed [49:0] prod [3][3];
  epm_pkg::coord_t   scaled [3][3];

  epm_pkg::coord_t   hold_rows [4][3];
  logic              hold_valid;
  logic [1:0]        row;

  function automatic epm_pkg::coord_t round_sat(input logic signed [49:0] v);
    logic signed [49:0] w;
    w = (v + 50'sd16384) >>> 15;
    if (w > 50'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (w < -50'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return w[31:0];
  endfunction

  assign side_in.scale = {scale_z, scale_y, scale_x};
  assign side_in.location = {location_z, location_y, location_x};

  assign out_done = result_valid && !result_stall && (row == epm_pkg::LAST_ROW);
  assign take = !hold_valid || out_done;
  assign en = !valid[DEPTH] || take;
  assign request_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[DEPTH-1:1], request_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side_in;
      for (int k = 2; k <= DEPTH; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  epm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(pitch_angle), .sn(sp), .cs(cp)
  );
  epm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(yaw_angle), .sn(sy), .cs(cy)
  );
  epm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(roll_angle), .sn(sr), .cs(cr)
  );

  epm_rotate u_rotate (
    .clk(clk), .en(en),
    .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
    .e(e)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= 50'($signed(side[ROT_END].scale[i])) * 50'(e[i][j]);
          scaled[i][j] <= round_sat(prod[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      row <= '0;
    end else if (take) begin
      hold_valid <= valid[DEPTH];
      row <= '0;
    end else if (result_valid && !result_stall) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          hold_rows[i][j] <= scaled[i][j];
        end
        hold_rows[3][i] <= $signed(side[DEPTH].location[i]);
      end
    end
  end

  assign result_valid = hold_valid;
  assign row_number = row;
  assign first_column = hold_rows[row][0];
  assign second_column = hold_rows[row][1];
  assign third_column = hold_rows[row][2];
  assign homogeneous_one = (row == epm_pkg::LAST_ROW);
  assign last_row = (row == epm_pkg::LAST_ROW);

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && (row_number != epm_pkg::LAST_ROW)
    |=> result_valid && (row_number == $past(row_number) + 2'd1))
    else $error("Row sequence skipped or repeated a row.");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> valid[1])
    else $error("Accepted request did not enter the pipeline.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(valid[DEPTH]) && hold_valid)
    else $error("Pipeline moved while the row sequencer was busy.");

  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_row |-> homogeneous_one && (row_number == epm_pkg::LAST_ROW))
    else $error("Location row flags are inconsistent.");

endmodule

### tb/sv/euler_placement_matrix_tb.sv
// Testbench for euler_placement_matrix: drives angle, scale and location requests and checks
// every emitted matrix row against a built-in fixed-point predictor of the same arithmetic.
// Depends on epm_pkg and the design folder.
module euler_placement_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic        hom;
    logic        last;
  } row_t;

  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  logic [15:0] pitch_angle = '0;
  logic [15:0] yaw_angle = '0;
  logic [15:0] roll_angle = '0;
  epm_pkg::coord_t scale_x = '0;
  epm_pkg::coord_t scale_y = '0;
  epm_pkg::coord_t scale_z = '0;
  epm_pkg::coord_t location_x = '0;
  epm_pkg::coord_t location_y = '0;
  epm_pkg::coord_t location_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] row_number;
  epm_pkg::coord_t first_column;
  epm_pkg::coord_t second_column;
  epm_pkg::coord_t third_column;
  logic homogeneous_one;
  logic last_row;

  row_t expected_rows[$];
  int failures = 0;
  bit calm = 1'b0;

  euler_placement_matrix dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint rnd_shift(longint v, int s);
    longint w;
    longint one;
    one = 64'sd1 <<< s;
    w = v + (one >>> 1);
    if (w >= 0) return w >>> s;
    return -((-w + one - 1) >>> s);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > 32768) return 32768;
    return v;
  endfunction

  task automatic trig(input logic [15:0] ang, output longint sn, output longint cs);
    logic [1:0] quad;
    longint unsigned r, x, x2, t, k;
    longint ssum, csum, s, c;
    quad = ang[15:14];
    r = ang[13:0];
    x = (r * 64'd1686629713 + 64'd8192) >> 14;
    x2 = (x * x) >> 30;
    t = x;
    ssum = x;
    for (k = 1; k <= 6; k++) begin
      t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
      ssum += (k & 1) ? -longint'(t) : longint'(t);
    end
    t = 64'd1 << 30;
    csum = t;
    for (k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / ((2 * k - 1) * (2 * k));
      csum += (k & 1) ? -longint'(t) : longint'(t);
    end
    s = clamp_unit(rnd_shift(ssum, 15));
    c = clamp_unit(rnd_shift(csum, 15));
    case (quad)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  function automatic logic [31:0] scaled(longint sc, longint el);
    longint v;
    v = rnd_shift(sc * el, 15);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_matrix();
    longint sp, cp, sy, cy, sr, cr;
    longint e[3][3];
    longint sc[3];
    row_t r;
    trig(pitch_angle, sp, cp);
    trig(yaw_angle, sy, cy);
    trig(roll_angle, sr, cr);
    e[0][0] = rnd_shift(cp * cy, 15);
    e[0][1] = rnd_shift(cp * sy, 15);
    e[0][2] = sp;
    e[1][0] = rnd_shift(sr * sp * cy - cr * sy * 32768, 30);
    e[1][1] = rnd_shift(sr * sp * sy + cr * cy * 32768, 30);
    e[1][2] = rnd_shift(-(sr * cp), 15);
    e[2][0] = rnd_shift(-(cr * sp * cy + sr * sy * 32768), 30);
    e[2][1] = rnd_shift(cy * sr * 32768 - cr * sp * sy, 30);
    e[2][2] = rnd_shift(cr * cp, 15);
    sc[0] = longint'(scale_x);
    sc[1] = longint'(scale_y);
    sc[2] = longint'(scale_z);
    for (int i = 0; i < 3; i++) begin
      r.row = i[1:0];
      r.c0 = scaled(sc[i], e[i][0]);
      r.c1 = scaled(sc[i], e[i][1]);
      r.c2 = scaled(sc[i], e[i][2]);
      r.hom = 1'b0;
      r.last = 1'b0;
      expected_rows.push_back(r);
    end
    r.row = epm_pkg::LAST_ROW;
    r.c0 = location_x;
    r.c1 = location_y;
    r.c2 = location_z;
    r.hom = 1'b1;
    r.last = 1'b1;
    expected_rows.push_back(r);
  endtask

  task automatic send_request(input logic [15:0] p, y, rl, input logic [31:0] sx, sy, sz,
                              input logic [31:0] lx, ly, lz);
    while (!calm && $urandom_range(99) < 10) begin
      request_valid <= 1'b0;
      @(negedge clk);
    end
    request_valid <= 1'b1;
    pitch_angle <= p;
    yaw_angle <= y;
    roll_angle <= rl;
    scale_x <= sx;
    scale_y <= sy;
    scale_z <= sz;
    location_x <= lx;
    location_y <= ly;
    location_z <= lz;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    predict_matrix();
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return {2'($urandom_range(3)), 14'h0};
      1: return {2'($urandom_range(3)), 14'h3fff};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    request_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                             16'hffff, 16'h3fff, 16'h2000, 16'h1234};
    for (int i = 0; i < 8; i++)
      send_request(angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8], 32'h0001_0000,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0);
    send_request(16'h4000, 16'h0, 16'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(16'hc000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_request(16'hffff, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'hffff_ffff, 32'h0, 32'h8000_0000);
    send_request(16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_request(rand_angle(), rand_angle(), rand_angle(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    test_random(60);
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    row_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected row %0d", row_number);
        failures++;
      end else begin
        e = expected_rows.pop_front();
        if (row_number !== e.row) begin
          $error("row_number expected %0d actual %0d", e.row, row_number);
          failures++;
        end
        if (first_column !== e.c0) begin
          $error("first_column expected %h actual %h", e.c0, first_column);
          failures++;
        end
        if (second_column !== e.c1) begin
          $error("second_column expected %h actual %h", e.c1, second_column);
          failures++;
        end
        if (third_column !== e.c2) begin
          $error("third_column expected %h actual %h", e.c2, third_column);
          failures++;
        end
        if (homogeneous_one !== e.hom) begin
          $error("homogeneous_one expected %0d actual %0d", e.hom, homogeneous_one);
          failures++;
        end
        if (last_row !== e.last) begin
          $error("last_row expected %0d actual %0d", e.last, last_row);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(120);
    wait_drained();
    test_back_to_back();
    test_random(120);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && expected_rows.size() == 0) begin
      $display("euler_placement_matrix_tb passed");
    end else begin
      $display("euler_placement_matrix_tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("euler_placement_matrix_tb failed");
    $finish;
  end
endmodule
